// File: sv/dcf_pkg.sv
`timescale 1ns / 1ps

package dcf_pkg;

  localparam int DurationWidthDefault = 24;
  localparam int FrameLen             = 59;
  localparam int SampleRateWidth      = 20;

  localparam logic [SampleRateWidth-1:0] SampleRateReset = 20'd48000;

  // window bounds as numerator / denominator in seconds
  localparam int GapLoNum  = 16;
  localparam int GapHiNum  = 21;
  localparam int GapDen    = 10;
  localparam int Bit0LoNum = 8;
  localparam int Bit0HiNum = 12;
  localparam int Bit1LoNum = 18;
  localparam int Bit1HiNum = 22;
  localparam int BitDen    = 100;

  localparam logic [11:0] YearBase = 12'd2000;

  localparam logic [3:0] StIgnored    = 4'd0;
  localparam logic [3:0] StBitStored  = 4'd1;
  localparam logic [3:0] StMinStart   = 4'd2;
  localparam logic [3:0] StPulseErr   = 4'd3;
  localparam logic [3:0] StTimeValid  = 4'd4;
  localparam logic [3:0] StBadMarkers = 4'd5;
  localparam logic [3:0] StBadOffset  = 4'd6;
  localparam logic [3:0] StParMinute  = 4'd7;
  localparam logic [3:0] StParHour    = 4'd8;
  localparam logic [3:0] StParDate    = 4'd9;

  typedef struct packed {
    logic                decode;
    logic [3:0]          status;
    logic [5:0]          bit_pos;
    logic [FrameLen-1:0] frame;
  } fe_entry_t;

  // bcd weights 1,2,4,8,10,20,40,80
  function automatic logic [7:0] bcd_weigh(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = {4'd0, b[3:0]};
    hi = {4'd0, b[7:4]};
    return lo + (hi << 3) + (hi << 1);
  endfunction

endpackage

// File: sv/dcf_front.sv
`timescale 1ns / 1ps

module dcf_front #(
  parameter int DurationWidth = dcf_pkg::DurationWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [dcf_pkg::SampleRateWidth-1:0] cfg_wr_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                level_i,
  input  logic [DurationWidth-1:0]            duration_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output dcf_pkg::fe_entry_t                  entry_o
);
  import dcf_pkg::*;

  localparam int ProdW = (DurationWidth + 7 > SampleRateWidth + 5) ?
                         DurationWidth + 7 : SampleRateWidth + 5;

  logic [SampleRateWidth-1:0] sr_q;
  logic [5:0]                 cnt_q, cnt_d;
  logic                       reading_q, reading_d;
  logic [FrameLen-1:0]        frame_q, frame_d;

  logic [ProdW-1:0] dur_w, sr_w, d_gap, d_bit;
  logic             gap_ok, b0_ok, b1_ok;

  assign dur_w = ProdW'(duration_i);
  assign sr_w  = ProdW'(sr_q);
  assign d_gap = dur_w * ProdW'(GapDen);
  assign d_bit = dur_w * ProdW'(BitDen);

  assign gap_ok = (d_gap >= sr_w * ProdW'(GapLoNum)) && (d_gap <= sr_w * ProdW'(GapHiNum));
  assign b0_ok  = (d_bit >= sr_w * ProdW'(Bit0LoNum)) && (d_bit <= sr_w * ProdW'(Bit0HiNum));
  assign b1_ok  = (d_bit >= sr_w * ProdW'(Bit1LoNum)) && (d_bit <= sr_w * ProdW'(Bit1HiNum));

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cnt_d          = cnt_q;
    reading_d      = reading_q;
    frame_d        = frame_q;
    entry_o.decode = 1'b0;
    entry_o.status = StIgnored;
    if (!level_i && gap_ok) begin
      cnt_d          = '0;
      reading_d      = 1'b1;
      entry_o.status = StMinStart;
    end else if (reading_q && level_i) begin
      if (b0_ok || b1_ok) begin
        if (cnt_q < 6'(FrameLen)) begin
          frame_d[cnt_q] = !b0_ok;
          cnt_d          = cnt_q + 6'd1;
        end
        entry_o.status = StBitStored;
        if (cnt_d == 6'(FrameLen)) begin
          reading_d      = 1'b0;
          entry_o.decode = 1'b1;
        end
      end else begin
        reading_d      = 1'b0;
        entry_o.status = StPulseErr;
      end
    end
    entry_o.bit_pos = cnt_d;
    entry_o.frame   = frame_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q      <= SampleRateReset;
      cnt_q     <= '0;
      reading_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        sr_q <= cfg_wr_data_i;
      end
      if (push_o) begin
        cnt_q     <= cnt_d;
        reading_q <= reading_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      frame_q <= frame_d;
    end
  end

endmodule

// File: sv/dcf_queue.sv
`timescale 1ns / 1ps

module dcf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dcf_pkg::fe_entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output dcf_pkg::fe_entry_t head_o
);
  import dcf_pkg::*;

  fe_entry_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: sv/dcf_back.sv
`timescale 1ns / 1ps

module dcf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  dcf_pkg::fe_entry_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         status_o,
  output logic [5:0]         bit_position_o,
  output logic [6:0]         minute_o,
  output logic [5:0]         hour_o,
  output logic [5:0]         day_o,
  output logic [2:0]         weekday_o,
  output logic [4:0]         month_o,
  output logic [11:0]        year_o,
  output logic               summer_time_o,
  output logic               leap_warning_o
);
  import dcf_pkg::*;

  logic                out_valid_q;
  logic [3:0]          status_q, status_d;
  logic [5:0]          pos_q;
  logic [6:0]          minute_q, minute_d;
  logic [5:0]          hour_q, hour_d, day_q, day_d;
  logic [2:0]          weekday_q, weekday_d;
  logic [4:0]          month_q, month_d;
  logic [11:0]         year_q, year_d;
  logic                summer_q, summer_d, leap_q, leap_d;
  logic [FrameLen-1:0] f;
  logic [7:0]          w_min, w_hour, w_day, w_wday, w_month, w_year;

  assign f     = head_i.frame;
  assign pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  assign w_min   = bcd_weigh({1'b0, f[27:21]});
  assign w_hour  = bcd_weigh({2'b0, f[34:29]});
  assign w_day   = bcd_weigh({2'b0, f[41:36]});
  assign w_wday  = bcd_weigh({5'b0, f[44:42]});
  assign w_month = bcd_weigh({3'b0, f[49:45]});
  assign w_year  = bcd_weigh(f[57:50]);

  always_comb begin
    status_d  = head_i.status;
    minute_d  = '0;
    hour_d    = '0;
    day_d     = '0;
    weekday_d = '0;
    month_d   = '0;
    year_d    = '0;
    summer_d  = 1'b0;
    leap_d    = 1'b0;
    if (head_i.decode) begin
      if (f[0] || !f[20]) begin
        status_d = StBadMarkers;
      end else if (f[17] == f[18]) begin
        status_d = StBadOffset;
      end else if (^f[28:21]) begin
        status_d = StParMinute;
      end else if (^f[35:29]) begin
        status_d = StParHour;
      end else if (^f[58:36]) begin
        status_d = StParDate;
      end else begin
        status_d  = StTimeValid;
        minute_d  = w_min[6:0];
        hour_d    = w_hour[5:0];
        day_d     = w_day[5:0];
        weekday_d = w_wday[2:0];
        month_d   = w_month[4:0];
        year_d    = YearBase + {4'd0, w_year};
        summer_d  = f[17];
        leap_d    = f[19];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q  <= status_d;
      pos_q     <= head_i.bit_pos;
      minute_q  <= minute_d;
      hour_q    <= hour_d;
      day_q     <= day_d;
      weekday_q <= weekday_d;
      month_q   <= month_d;
      year_q    <= year_d;
      summer_q  <= summer_d;
      leap_q    <= leap_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign bit_position_o = pos_q;
  assign minute_o       = minute_q;
  assign hour_o         = hour_q;
  assign day_o          = day_q;
  assign weekday_o      = weekday_q;
  assign month_o        = month_q;
  assign year_o         = year_q;
  assign summer_time_o  = summer_q;
  assign leap_warning_o = leap_q;

endmodule

// File: sv/dcf77_frame_decoder_top.sv
`timescale 1ns / 1ps

// dcf77 minute frame decoder
// input channel: one word per pulse event (level_i, duration_i in samples), taken
//   when in_valid_i is high and in_stall_o is low
// output channel: one result word per event, taken when out_valid_o is high and
//   out_stall_i is low; time fields are zero unless status_o reports a valid time
// cfg_wr_en_i writes cfg_wr_data_i into the sample rate register (48000 at reset);
//   write only while no event is in flight
// the front classifies each event in the cycle it is taken and updates the frame,
//   bit count and reading flag; a two-word queue feeds the back, which checks the
//   markers, offset bits and parity, weighs bcd fields into the output register
// a result passes from the queue entry into the output register, where it is taken
// throughput: one event per cycle while in_stall_o is low, with the window compare
//   combinational and the frame update registered in the front
// when out_stall_i holds the output, the queue absorbs events until both its words
//   are held, then in_stall_o rises
// reset clears the bit count, reading flag, queue and output valid; the frame
//   bits need no clearing since all 59 are written before a decode

module dcf77_frame_decoder_top #(
  parameter int DURATION_WIDTH = dcf_pkg::DurationWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [dcf_pkg::SampleRateWidth-1:0] cfg_wr_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                level_i,
  input  logic [DURATION_WIDTH-1:0]           duration_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [3:0]                          status_o,
  output logic [5:0]                          bit_position_o,
  output logic [6:0]                          minute_o,
  output logic [5:0]                          hour_o,
  output logic [5:0]                          day_o,
  output logic [2:0]                          weekday_o,
  output logic [4:0]                          month_o,
  output logic [11:0]                         year_o,
  output logic                                summer_time_o,
  output logic                                leap_warning_o
);
  import dcf_pkg::*;

  fe_entry_t push_entry, head;
  logic      push, pop, q_full, q_empty;

  dcf_front #(
    .DurationWidth(DURATION_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .level_i      (level_i),
    .duration_i   (duration_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  dcf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (head)
  );

  dcf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .bit_position_o(bit_position_o),
    .minute_o      (minute_o),
    .hour_o        (hour_o),
    .day_o         (day_o),
    .weekday_o     (weekday_o),
    .month_o       (month_o),
    .year_o        (year_o),
    .summer_time_o (summer_time_o),
    .leap_warning_o(leap_warning_o)
  );

endmodule
